// File: rtl/core/pla_pkg.sv
// pla_pkg: widths, band table and shared types for point_light_attenuation
// no dependencies; used by pla_div_step and point_light_attenuation
`default_nettype none

package pla_pkg;

  localparam int DIST_W     = 25;
  localparam int ATT_W      = 17;
  localparam int BAND_W     = 4;
  localparam int LIN_W      = 23;
  localparam int QUAD_W     = 32;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int DEN_W      = 48;
  localparam int TABLE_LEN  = 12;
  localparam int NUM_BANDS  = 12;
  localparam int BANDS_USED = (NUM_BANDS < 1) ? 1 :
                              ((NUM_BANDS > TABLE_LEN) ? TABLE_LEN : NUM_BANDS);
  localparam int DIV_STEPS  = ATT_W;
  localparam int FRONT_STG  = 4;
  localparam int STAGES     = FRONT_STG + DIV_STEPS;

  // word carried through the divider steps
  typedef struct packed {
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem;
    logic [ATT_W-1:0]  low;
    logic [ATT_W-1:0]  quo;
    logic [BAND_W-1:0] band;
  } div_word_t;

  // band lower limit, q17.8
  function automatic logic [DIST_W-1:0] band_lo(input logic [BAND_W-1:0] i);
    logic [DIST_W-1:0] r;
    unique case (i)
      4'd0:    r = 25'd0;
      4'd1:    r = 25'd3328;
      4'd2:    r = 25'd5120;
      4'd3:    r = 25'd8192;
      4'd4:    r = 25'd12800;
      4'd5:    r = 25'd16640;
      4'd6:    r = 25'd25600;
      4'd7:    r = 25'd40960;
      4'd8:    r = 25'd51200;
      4'd9:    r = 25'd83200;
      4'd10:   r = 25'd153600;
      4'd11:   r = 25'd832000;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // band upper limit, exclusive
  function automatic logic [DIST_W-1:0] band_hi(input logic [BAND_W-1:0] i);
    logic [DIST_W-1:0] r;
    unique case (i)
      4'd0:    r = 25'd3328;
      4'd1:    r = 25'd5120;
      4'd2:    r = 25'd8192;
      4'd3:    r = 25'd12800;
      4'd4:    r = 25'd16640;
      4'd5:    r = 25'd25600;
      4'd6:    r = 25'd40960;
      4'd7:    r = 25'd51200;
      4'd8:    r = 25'd83200;
      4'd9:    r = 25'd153600;
      4'd10:   r = 25'd832000;
      4'd11:   r = 25'd25599744;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

  // linear coefficient, q0.24
  function automatic logic [LIN_W-1:0] band_lin(input logic [BAND_W-1:0] i);
    logic [LIN_W-1:0] r;
    unique case (i)
      4'd0:    r = 23'd5872026;
      4'd1:    r = 23'd3019899;
      4'd2:    r = 23'd1845494;
      4'd3:    r = 23'd1174405;
      4'd4:    r = 23'd754975;
      4'd5:    r = 23'd587203;
      4'd6:    r = 23'd369099;
      4'd7:    r = 23'd234881;
      4'd8:    r = 23'd184549;
      4'd9:    r = 23'd117441;
      4'd10:   r = 23'd58720;
      4'd11:   r = 23'd11744;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // quadratic coefficient, q0.32
  function automatic logic [QUAD_W-1:0] band_quad(input logic [BAND_W-1:0] i);
    logic [QUAD_W-1:0] r;
    unique case (i)
      4'd0:    r = 32'd3865470566;
      4'd1:    r = 32'd944892805;
      4'd2:    r = 32'd429496730;
      4'd3:    r = 32'd150323855;
      4'd4:    r = 32'd68719477;
      4'd5:    r = 32'd36507222;
      4'd6:    r = 32'd15891379;
      4'd7:    r = 32'd6012954;
      4'd8:    r = 32'd3865471;
      4'd9:    r = 32'd1503239;
      4'd10:   r = 32'd429497;
      4'd11:   r = 32'd15032;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // first band holding d, else the last band in use
  function automatic logic [BAND_W-1:0] pick_band(input logic [DIST_W-1:0] d);
    logic [BAND_W-1:0] r;
    logic              found;
    r     = BAND_W'(BANDS_USED - 1);
    found = 1'b0;
    for (int i = 0; i < BANDS_USED; i++) begin
      if (!found && d >= band_lo(BAND_W'(i)) && d < band_hi(BAND_W'(i))) begin
        r     = BAND_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pla_div_step.sv
// pla_div_step: one registered restoring step of the reciprocal divider
// depends on pla_pkg (div_word_t, widths)
`default_nettype none

module pla_div_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire pla_pkg::div_word_t word_i,
  output logic                   valid_o,
  output pla_pkg::div_word_t      word_o
);

  logic [pla_pkg::DEN_W:0]   trial;
  logic [pla_pkg::DEN_W:0]   diff;
  logic                      ge;
  pla_pkg::div_word_t        word_d, word_q;
  logic                      valid_q;

  // shift in next numerator bit, subtract divisor where it fits
  always_comb begin
    trial  = {word_i.rem, word_i.low[pla_pkg::ATT_W-1]};
    ge     = trial >= {1'b0, word_i.den};
    diff   = trial - {1'b0, word_i.den};
    word_d = word_i;
    word_d.rem = ge ? diff[pla_pkg::DEN_W-1:0] : trial[pla_pkg::DEN_W-1:0];
    word_d.low = {word_i.low[pla_pkg::ATT_W-2:0], 1'b0};
    word_d.quo = {word_i.quo[pla_pkg::ATT_W-2:0], ge};
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// File: rtl/core/point_light_attenuation.sv
// point_light_attenuation: banded quadratic falloff and pipelined reciprocal
// depends on pla_pkg and pla_div_step
//
// Use: one distance word (q17.8) enters on in_valid_i/in_stall_o; one word
// with attenuation (q1.16, 1/(1 + lin*d + quad*d*d)) and band_index leaves
// on out_valid_o/out_stall_i. Both channels move a word at a rising edge
// where valid is high and stall is low.
// Pipeline: four front stages (band pick and d*d, coefficient products,
// denominator sum, numerator set-up) and seventeen divider stages, one
// quotient bit each.
// Throughput: one word per cycle while the receiver does not stall.
// Reset clears every stage valid bit; the payload registers are not reset.
// When the receiver stalls, the output word holds and earlier stages keep
// filling empty slots, so the input stalls only once every stage is full.
`default_nettype none

module point_light_attenuation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pla_pkg::DIST_W-1:0]   distance_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [pla_pkg::ATT_W-1:0]         attenuation_o,
  output logic [pla_pkg::BAND_W-1:0]        band_index_o
);

  localparam int NS = pla_pkg::STAGES;
  localparam int NF = pla_pkg::FRONT_STG;
  localparam int ND = pla_pkg::DIV_STEPS;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // stage 1: band pick and distance squared
  logic                        v1_q;
  logic [pla_pkg::DIST_W-1:0]  d1_q;
  logic [pla_pkg::SQ_W-1:0]    sq1_q;
  logic [pla_pkg::BAND_W-1:0]  b1_q;

  // stage 2: coefficient products
  logic                                      v2_q;
  logic [pla_pkg::BAND_W-1:0]                b2_q;
  logic [pla_pkg::LIN_W+pla_pkg::DIST_W-1:0] lind2_q;
  logic [pla_pkg::QUAD_W+17:0]               qhi2_q;
  logic [63:0]                               qlo2_q;
  logic [pla_pkg::LIN_W-1:0]                 lin_c;
  logic [pla_pkg::QUAD_W-1:0]                quad_c;

  // stage 3: denominator
  logic                        v3_q;
  logic [pla_pkg::BAND_W-1:0]  b3_q;
  logic [pla_pkg::DEN_W-1:0]   den3_q;
  logic [65:0]                 den_sum;

  // stage 4: numerator set-up
  logic                        v4_q;
  pla_pkg::div_word_t          div4_q;
  pla_pkg::div_word_t          div4_d;
  logic [pla_pkg::DEN_W:0]     num;

  pla_pkg::div_word_t          dw [ND];

  // stall chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];
  assign vld[0] = v1_q;
  assign vld[1] = v2_q;
  assign vld[2] = v3_q;
  assign vld[3] = v4_q;

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en[0]) v1_q <= in_valid_i;
      if (en[1]) v2_q <= v1_q;
      if (en[2]) v3_q <= v2_q;
      if (en[3]) v4_q <= v3_q;
    end
  end

  // stage 2 and 3 arithmetic
  always_comb begin
    lin_c   = pla_pkg::band_lin(b1_q);
    quad_c  = pla_pkg::band_quad(b1_q);
    den_sum = (66'd1 << 32) + 66'(lind2_q) + (66'(qhi2_q) << 16) + 66'(qlo2_q >> 16);
  end

  // stage 4: round-half-up numerator, top bits seed the remainder
  always_comb begin
    num        = (49'd1 << pla_pkg::DEN_W) + 49'(den3_q >> 1);
    div4_d.den  = den3_q;
    div4_d.rem  = pla_pkg::DEN_W'(num[pla_pkg::DEN_W:pla_pkg::ATT_W]);
    div4_d.low  = num[pla_pkg::ATT_W-1:0];
    div4_d.quo  = '0;
    div4_d.band = b3_q;
  end

  // front payload
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_q  <= distance_i;
      sq1_q <= pla_pkg::SQ_W'(distance_i) * pla_pkg::SQ_W'(distance_i);
      b1_q  <= pla_pkg::pick_band(distance_i);
    end
    if (en[1]) begin
      b2_q    <= b1_q;
      lind2_q <= (pla_pkg::LIN_W + pla_pkg::DIST_W)'(lin_c)
               * (pla_pkg::LIN_W + pla_pkg::DIST_W)'(d1_q);
      qhi2_q  <= (pla_pkg::QUAD_W + 18)'(quad_c)
               * (pla_pkg::QUAD_W + 18)'(sq1_q[pla_pkg::SQ_W-1:32]);
      qlo2_q  <= 64'(quad_c) * 64'(sq1_q[31:0]);
    end
    if (en[2]) begin
      b3_q   <= b2_q;
      den3_q <= den_sum[pla_pkg::DEN_W-1:0];
    end
    if (en[3]) begin
      div4_q <= div4_d;
    end
  end

  // divider steps, one quotient bit each
  for (genvar g = 0; g < ND; g++) begin : g_div
    if (g == 0) begin : g_first
      pla_div_step u_step (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[NF]),
        .valid_i (v4_q),
        .word_i  (div4_q),
        .valid_o (vld[NF]),
        .word_o  (dw[0])
      );
    end else begin : g_next
      pla_div_step u_step (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[NF+g]),
        .valid_i (vld[NF+g-1]),
        .word_i  (dw[g-1]),
        .valid_o (vld[NF+g]),
        .word_o  (dw[g])
      );
    end
  end

  assign out_valid_o   = vld[NS-1];
  assign attenuation_o = dw[ND-1].quo;
  assign band_index_o  = dw[ND-1].band;

  // checks
  a_att_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (attenuation_o <= 17'd65536) && (attenuation_o != '0))
    else $error("attenuation out of range");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> band_index_o < pla_pkg::BAND_W'(pla_pkg::BANDS_USED))
    else $error("band index out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&vld)))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
